// ===== src/mcid_pkg.sv =====
// ----------------------------------------------------------------------------
// Debouncer package
// Shared types, request codes and reset constants of the input debouncer.
// ----------------------------------------------------------------------------
package mcid_pkg;

    // Widths of the timestamp, the debounce times, the request code and the register index.
    localparam int TIME_W = 32;
    localparam int DEB_W  = 16;
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 3;

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [DEB_W-1:0]  t_deb;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    // Request codes carried by an input beat.
    localparam t_req REQ_POLL      = 2'd0;
    localparam t_req REQ_WRITE_OUT = 2'd1;
    localparam t_req REQ_ALL_OFF   = 2'd2;
    localparam t_req REQ_CAPTURE   = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_IN_ACTIVE_HIGH  = 3'd0;
    localparam t_cfg_idx CFG_OUT_ACTIVE_HIGH = 3'd1;
    localparam t_cfg_idx CFG_DEB_SHORT       = 3'd2;
    localparam t_cfg_idx CFG_DEB_LONG        = 3'd3;
    localparam t_cfg_idx CFG_LONG_MASK       = 3'd4;

    // Reset values of the configuration registers, cut to width where used.
    localparam logic [31:0] IN_ACTIVE_HIGH_RST  = 32'd176;
    localparam logic [31:0] OUT_ACTIVE_HIGH_RST = 32'd7;
    localparam t_deb        DEB_SHORT_RST       = 16'd20;
    localparam t_deb        DEB_LONG_RST        = 16'd50;
    localparam logic [31:0] LONG_MASK_RST       = 32'd128;

    // Command from the top level to every channel.
    typedef struct packed {
        logic adv;
        logic poll;
        logic capture;
    } t_chan_cmd;

    // Next state and edge flags reported by one channel.
    typedef struct packed {
        logic stable;
        logic rose;
        logic fell;
    } t_chan_res;

endpackage

// ===== src/mcid_in_if.sv =====
// ----------------------------------------------------------------------------
// Debouncer request channel
// Valid/ready channel that carries one request beat into the debouncer.
// ----------------------------------------------------------------------------
interface mcid_in_if #(
    parameter int NUM_INPUTS = 8,
    parameter int OUT_IDX_W  = 2
) ();
    logic                  valid;
    logic                  ready;
    mcid_pkg::t_req        req_type;
    logic [NUM_INPUTS-1:0] raw_pins;
    mcid_pkg::t_time       now_ms;
    logic [OUT_IDX_W-1:0]  out_index;
    logic                  out_value;

    modport source (
        output valid, req_type, raw_pins, now_ms, out_index, out_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, raw_pins, now_ms, out_index, out_value,
        output ready
    );
endinterface

// ===== src/mcid_out_if.sv =====
// ----------------------------------------------------------------------------
// Debouncer result channel
// Valid/ready channel that carries one result beat out of the debouncer.
// ----------------------------------------------------------------------------
interface mcid_out_if #(
    parameter int NUM_INPUTS  = 8,
    parameter int NUM_OUTPUTS = 3
) ();
    logic                   valid;
    logic                   ready;
    logic [NUM_INPUTS-1:0]  stable_levels;
    logic [NUM_INPUTS-1:0]  rose_mask;
    logic [NUM_INPUTS-1:0]  fell_mask;
    logic                   any_active;
    logic [NUM_OUTPUTS-1:0] out_logic;
    logic [NUM_OUTPUTS-1:0] out_pins;

    modport source (
        output valid, stable_levels, rose_mask, fell_mask, any_active,
               out_logic, out_pins,
        input  ready
    );

    modport sink (
        input  valid, stable_levels, rose_mask, fell_mask, any_active,
               out_logic, out_pins,
        output ready
    );
endinterface

// ===== src/multi_channel_input_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-channel input debouncer
// Debounces the input pins per channel and keeps polarity-mapped outputs.
// ----------------------------------------------------------------------------
// Flow: an accepted request beat waits in the request register and moves on
// into the result register once that register is free or drains.
// Throughput: one beat per cycle unless results stall; the request register
// feeds one level of per-channel subtract and compare into the result register.
// Reset: configuration takes its default values, channel and output state
// clears to zero, and both the request and result registers are empty.
// ----------------------------------------------------------------------------
module multi_channel_input_debouncer_unit #(
    parameter int   NUM_INPUTS  = 8,
    parameter int   NUM_OUTPUTS = 3,
    localparam int  OUT_IDX_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1,
    localparam int  CFG_W       = (NUM_INPUTS > NUM_OUTPUTS)
                                ? ((NUM_INPUTS > 16) ? NUM_INPUTS : 16)
                                : ((NUM_OUTPUTS > 16) ? NUM_OUTPUTS : 16)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  mcid_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    mcid_in_if.sink                i_req,
    mcid_out_if.source             o_res
);

    localparam logic [OUT_IDX_W:0] NUM_OUT_L = (OUT_IDX_W+1)'(NUM_OUTPUTS);

    // Configuration registers.
    logic [NUM_INPUTS-1:0]  r_in_ah;
    logic [NUM_OUTPUTS-1:0] r_out_ah;
    mcid_pkg::t_deb         r_deb_short;
    mcid_pkg::t_deb         r_deb_long;
    logic [NUM_INPUTS-1:0]  r_long_mask;

    // Request register.
    logic                   r_in_valid;
    mcid_pkg::t_req         r_in_req;
    logic [NUM_INPUTS-1:0]  r_in_pins;
    mcid_pkg::t_time        r_in_now;
    logic [OUT_IDX_W-1:0]   r_in_idx;
    logic                   r_in_val;

    // Output state and result register.
    logic [NUM_OUTPUTS-1:0] r_out_logic;
    logic [NUM_OUTPUTS-1:0] n_out_logic;
    logic                   r_out_valid;
    logic [NUM_INPUTS-1:0]  r_res_stable;
    logic [NUM_INPUTS-1:0]  r_res_rose;
    logic [NUM_INPUTS-1:0]  r_res_fell;
    logic                   r_res_any;
    logic [NUM_OUTPUTS-1:0] r_res_logic;
    logic [NUM_OUTPUTS-1:0] r_res_pins;

    logic                   adv;
    logic [NUM_INPUTS-1:0]  norm;
    logic [NUM_INPUTS-1:0]  n_stable;
    logic [NUM_INPUTS-1:0]  n_rose;
    logic [NUM_INPUTS-1:0]  n_fell;
    mcid_pkg::t_chan_cmd    chan_cmd;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ah     <= mcid_pkg::IN_ACTIVE_HIGH_RST[NUM_INPUTS-1:0];
            r_out_ah    <= mcid_pkg::OUT_ACTIVE_HIGH_RST[NUM_OUTPUTS-1:0];
            r_deb_short <= mcid_pkg::DEB_SHORT_RST;
            r_deb_long  <= mcid_pkg::DEB_LONG_RST;
            r_long_mask <= mcid_pkg::LONG_MASK_RST[NUM_INPUTS-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcid_pkg::CFG_IN_ACTIVE_HIGH: begin
                    r_in_ah <= i_cfg_data[NUM_INPUTS-1:0];
                end
                mcid_pkg::CFG_OUT_ACTIVE_HIGH: begin
                    r_out_ah <= i_cfg_data[NUM_OUTPUTS-1:0];
                end
                mcid_pkg::CFG_DEB_SHORT: begin
                    r_deb_short <= i_cfg_data[mcid_pkg::DEB_W-1:0];
                end
                mcid_pkg::CFG_DEB_LONG: begin
                    r_deb_long <= i_cfg_data[mcid_pkg::DEB_W-1:0];
                end
                mcid_pkg::CFG_LONG_MASK: begin
                    r_long_mask <= i_cfg_data[NUM_INPUTS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The request beat advances when the result register is free or drains.
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_req  <= i_req.req_type;
            r_in_pins <= i_req.raw_pins;
            r_in_now  <= i_req.now_ms;
            r_in_idx  <= i_req.out_index;
            r_in_val  <= i_req.out_value;
        end
    end

    // Normalize the pins so that 1 always means active.
    assign norm = ~(r_in_pins ^ r_in_ah);

    assign chan_cmd.adv     = adv;
    assign chan_cmd.poll    = (r_in_req == mcid_pkg::REQ_POLL);
    assign chan_cmd.capture = (r_in_req == mcid_pkg::REQ_CAPTURE);

    // One channel per input pin.
    for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_chan
        mcid_pkg::t_chan_res ch_res;

        mcid_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (chan_cmd),
            .i_raw   (norm[g]),
            .i_now   (r_in_now),
            .i_deb   (r_long_mask[g] ? r_deb_long : r_deb_short),
            .o_res   (ch_res)
        );

        assign n_stable[g] = ch_res.stable;
        assign n_rose[g]   = ch_res.rose;
        assign n_fell[g]   = ch_res.fell;
    end

    // Output logic state; a write to a missing output is ignored.
    always_comb begin
        n_out_logic = r_out_logic;
        unique case (r_in_req) inside
            mcid_pkg::REQ_WRITE_OUT: begin
                if ({1'b0, r_in_idx} < NUM_OUT_L) begin
                    for (int k = 0; k < NUM_OUTPUTS; k++) begin
                        if (r_in_idx == OUT_IDX_W'(k)) begin
                            n_out_logic[k] = r_in_val;
                        end
                    end
                end
            end
            mcid_pkg::REQ_ALL_OFF, mcid_pkg::REQ_CAPTURE: begin
                n_out_logic = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_logic <= '0;
        end else if (adv) begin
            r_out_logic <= n_out_logic;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res_stable <= n_stable;
            r_res_rose   <= n_rose;
            r_res_fell   <= n_fell;
            r_res_any    <= |n_stable;
            r_res_logic  <= n_out_logic;
            r_res_pins   <= ~(n_out_logic ^ r_out_ah);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.stable_levels = r_res_stable;
    assign o_res.rose_mask     = r_res_rose;
    assign o_res.fell_mask     = r_res_fell;
    assign o_res.any_active    = r_res_any;
    assign o_res.out_logic     = r_res_logic;
    assign o_res.out_pins      = r_res_pins;

    // A channel cannot rise and fall on the same beat.
    a_edge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.rose_mask & o_res.fell_mask) == '0))
        else $error("rise and fall flagged on the same channel");

    // Edge flags agree with the stable levels they produced.
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.rose_mask & ~o_res.stable_levels) == '0 &&
                         (o_res.fell_mask &  o_res.stable_levels) == '0))
        else $error("edge flag disagrees with stable level");

    // The boot inhibit flag follows the stable levels.
    a_any_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.any_active == (|o_res.stable_levels)))
        else $error("any_active does not match stable levels");

    // A pending request with an empty result register moves on next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("request beat did not advance into an empty result register");

endmodule

// ===== src/mcid_chan.sv =====
// ----------------------------------------------------------------------------
// Debouncer channel
// State of one input channel: last raw level, stable level, change time.
// ----------------------------------------------------------------------------
module mcid_chan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcid_pkg::t_chan_cmd   i_cmd,
    input  logic                  i_raw,
    input  mcid_pkg::t_time       i_now,
    input  mcid_pkg::t_deb        i_deb,
    output mcid_pkg::t_chan_res   o_res
);

    logic            r_last;
    logic            r_stable;
    mcid_pkg::t_time r_change;
    logic            n_last;
    logic            n_stable;
    mcid_pkg::t_time n_change;
    mcid_pkg::t_time elapsed;
    logic            settled;
    logic            rose;
    logic            fell;

    // Wrapping time since the last raw change, against the debounce time.
    assign elapsed = i_now - r_change;
    assign settled = elapsed >= {{(mcid_pkg::TIME_W-mcid_pkg::DEB_W){1'b0}}, i_deb};

    // Next state for a poll or a capture; other requests leave it alone.
    always_comb begin
        n_last   = r_last;
        n_stable = r_stable;
        n_change = r_change;
        rose     = 1'b0;
        fell     = 1'b0;
        if (i_cmd.capture) begin
            n_last   = i_raw;
            n_stable = i_raw;
            n_change = i_now;
        end else if (i_cmd.poll) begin
            if (i_raw != r_last) begin
                n_last   = i_raw;
                n_change = i_now;
            end else if (i_raw != r_stable && settled) begin
                n_stable = i_raw;
                rose     = i_raw;
                fell     = !i_raw;
            end
        end
    end

    // State moves only when the request beat advances to the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_stable <= 1'b0;
            r_change <= '0;
        end else if (i_cmd.adv) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_change <= n_change;
        end
    end

    assign o_res.stable = n_stable;
    assign o_res.rose   = rose;
    assign o_res.fell   = fell;

endmodule

// ===== bench/tb_multi_channel_input_debouncer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the multi-channel input debouncer
// Drives request beats through the valid/ready request channel and checks
// every result beat against a table entry or a cycle-free predictor of the
// debounce channels and the output store. A directed table comes first, then
// random phases, each under its own register setting, all but one with random
// idling on both channels; one long result stall pushes back on requests.
// ----------------------------------------------------------------------------
module tb_multi_channel_input_debouncer_unit;

    localparam int NUM_CH      = 8;
    localparam int NUM_OUT     = 3;
    localparam int OUT_IDX_W   = 2;
    localparam int CFG_W       = 16;
    localparam int N_DIRECTED  = 22;
    localparam int RECONFIG_AT = 17;
    localparam int N_PHASES    = 5;
    localparam int PHASE_BEATS = 136;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 120;

    // One request beat.
    typedef struct packed {
        mcid_pkg::t_req       req;
        logic [NUM_CH-1:0]    pins;
        mcid_pkg::t_time      now;
        logic [OUT_IDX_W-1:0] idx;
        logic                 val;
    } t_beat;

    // One result beat: debounced levels, edges and output state.
    typedef struct packed {
        logic [NUM_CH-1:0]  stable;
        logic [NUM_CH-1:0]  rose;
        logic [NUM_CH-1:0]  fell;
        logic               any;
        logic [NUM_OUT-1:0] outs;
        logic [NUM_OUT-1:0] opins;
    } t_status;

    // A row of the directed table; want is used only where typed is set.
    typedef struct packed {
        t_beat   beat;
        logic    typed;
        t_status want;
    } t_vector;

    localparam t_status NO_STATUS = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    mcid_pkg::t_cfg_idx i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    mcid_in_if  #(.NUM_INPUTS(NUM_CH), .OUT_IDX_W(OUT_IDX_W)) req_if ();
    mcid_out_if #(.NUM_INPUTS(NUM_CH), .NUM_OUTPUTS(NUM_OUT)) res_if ();

    multi_channel_input_debouncer_unit #(
        .NUM_INPUTS (NUM_CH),
        .NUM_OUTPUTS(NUM_OUT)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if),
        .o_res     (res_if)
    );

    // Register copies held by the predictor.
    logic [NUM_CH-1:0]  cfg_in_pol;
    logic [NUM_OUT-1:0] cfg_out_pol;
    mcid_pkg::t_deb     cfg_short;
    mcid_pkg::t_deb     cfg_long;
    logic [NUM_CH-1:0]  cfg_long_sel;

    // Channel and output state held by the predictor.
    logic [NUM_CH-1:0]  pred_last_raw;
    logic [NUM_CH-1:0]  pred_stable;
    mcid_pkg::t_time    pred_stamp [NUM_CH];
    logic [NUM_OUT-1:0] pred_out_on;

    t_status pending_status_q [$];
    t_vector directed_rows [N_DIRECTED];

    int  mismatches = 0;
    int  beats_seen = 0;
    bit  idle_on    = 1'b1;

    always #5 i_clk = ~i_clk;

    // Advance the predicted channel and output state by one request beat.
    function automatic t_status predict_status(input t_beat b);
        t_status           r;
        logic [NUM_CH-1:0] lvl;
        mcid_pkg::t_deb    hold;
        mcid_pkg::t_time   age;
        r   = '0;
        lvl = ~(b.pins ^ cfg_in_pol);
        case (b.req)
            mcid_pkg::REQ_POLL: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    hold = cfg_long_sel[ch] ? cfg_long : cfg_short;
                    age  = b.now - pred_stamp[ch];
                    if (lvl[ch] != pred_last_raw[ch]) begin
                        pred_last_raw[ch] = lvl[ch];
                        pred_stamp[ch]    = b.now;
                    end else if (lvl[ch] != pred_stable[ch] &&
                                 age >= mcid_pkg::t_time'(hold)) begin
                        pred_stable[ch] = lvl[ch];
                        if (lvl[ch]) begin
                            r.rose[ch] = 1'b1;
                        end else begin
                            r.fell[ch] = 1'b1;
                        end
                    end
                end
            end
            mcid_pkg::REQ_WRITE_OUT: begin
                if (int'(b.idx) < NUM_OUT) begin
                    pred_out_on[b.idx] = b.val;
                end
            end
            mcid_pkg::REQ_ALL_OFF: begin
                pred_out_on = '0;
            end
            mcid_pkg::REQ_CAPTURE: begin
                pred_last_raw = lvl;
                pred_stable   = lvl;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    pred_stamp[ch] = b.now;
                end
                pred_out_on = '0;
            end
        endcase
        r.stable = pred_stable;
        r.any    = |pred_stable;
        r.outs   = pred_out_on;
        r.opins  = ~(pred_out_on ^ cfg_out_pol);
        return r;
    endfunction

    // Offer one beat, wait for it to be taken and queue what it should give.
    task automatic send_beat(input t_beat b, input logic typed, input t_status want);
        t_status predicted;
        while (idle_on && $urandom_range(0, 99) < 6) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= b.req;
        req_if.raw_pins  <= b.pins;
        req_if.now_ms    <= b.now;
        req_if.out_index <= b.idx;
        req_if.out_value <= b.val;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = predict_status(b);
        pending_status_q.push_back(typed ? want : predicted);
    endtask

    // Stop offering beats and wait until every result has come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_status_q.size() != 0);
    endtask

    // Drive one register write; the caller lowers the write enable.
    task automatic write_reg(input mcid_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            mcid_pkg::CFG_IN_ACTIVE_HIGH:  cfg_in_pol   = data[NUM_CH-1:0];
            mcid_pkg::CFG_OUT_ACTIVE_HIGH: cfg_out_pol  = data[NUM_OUT-1:0];
            mcid_pkg::CFG_DEB_SHORT:       cfg_short    = data;
            mcid_pkg::CFG_DEB_LONG:        cfg_long     = data;
            mcid_pkg::CFG_LONG_MASK:       cfg_long_sel = data[NUM_CH-1:0];
            default: ;
        endcase
    endtask

    // Drain, then write every register, plus one random index past the last register.
    task automatic setup_regs(input logic [CFG_W-1:0] in_pol, input logic [CFG_W-1:0] out_pol,
                              input logic [CFG_W-1:0] short_ms, input logic [CFG_W-1:0] long_ms,
                              input logic [CFG_W-1:0] long_sel);
        drain();
        write_reg(mcid_pkg::CFG_IN_ACTIVE_HIGH, in_pol);
        write_reg(mcid_pkg::CFG_OUT_ACTIVE_HIGH, out_pol);
        write_reg(mcid_pkg::CFG_DEB_SHORT, short_ms);
        write_reg(mcid_pkg::CFG_DEB_LONG, long_ms);
        write_reg(mcid_pkg::CFG_LONG_MASK, long_sel);
        write_reg(mcid_pkg::t_cfg_idx'($urandom_range(int'(mcid_pkg::CFG_LONG_MASK) + 1,
                                                      (1 << mcid_pkg::IDX_W) - 1)),
                  CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Random traffic: time mostly creeps, pins mostly hold or bounce one bit.
    task automatic run_random_phase(input int count);
        t_beat             b;
        int                roll;
        logic [NUM_CH-1:0] pin_level;
        mcid_pkg::t_time   clock_ms;
        pin_level = NUM_CH'($urandom);
        clock_ms  = $urandom;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                clock_ms = $urandom;
            end else if (roll < 8) begin
                clock_ms += $urandom_range(0, 70000);
            end else begin
                clock_ms += $urandom_range(0, 12);
            end
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                pin_level ^= NUM_CH'(1 << $urandom_range(0, NUM_CH - 1));
            end else if (roll < 25) begin
                pin_level = NUM_CH'($urandom);
            end
            b.pins = pin_level;
            b.now  = clock_ms;
            b.idx  = OUT_IDX_W'($urandom_range(0, (1 << OUT_IDX_W) - 1));
            b.val  = 1'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                b.req = mcid_pkg::REQ_POLL;
            end else if (roll < 90) begin
                b.req = mcid_pkg::REQ_WRITE_OUT;
            end else if (roll < 95) begin
                b.req = mcid_pkg::REQ_ALL_OFF;
            end else begin
                b.req = mcid_pkg::REQ_CAPTURE;
            end
            send_beat(b, 1'b0, NO_STATUS);
        end
    endtask

    // Main stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = mcid_pkg::CFG_IN_ACTIVE_HIGH;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = mcid_pkg::REQ_POLL;
        req_if.raw_pins  = '0;
        req_if.now_ms    = '0;
        req_if.out_index = '0;
        req_if.out_value = 1'b0;

        cfg_in_pol    = mcid_pkg::IN_ACTIVE_HIGH_RST[NUM_CH-1:0];
        cfg_out_pol   = mcid_pkg::OUT_ACTIVE_HIGH_RST[NUM_OUT-1:0];
        cfg_short     = mcid_pkg::DEB_SHORT_RST;
        cfg_long      = mcid_pkg::DEB_LONG_RST;
        cfg_long_sel  = mcid_pkg::LONG_MASK_RST[NUM_CH-1:0];
        pred_last_raw = '0;
        pred_stable   = '0;
        pred_out_on   = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            pred_stamp[ch] = '0;
        end

        // Rows up to the reconfiguration run on the reset register values.
        directed_rows = '{
            // Nothing active after reset, all outputs off.
            '{'{mcid_pkg::REQ_POLL, 8'h4F, 32'd0, 2'd0, 1'b0}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 3'd0}},
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'd0, 1'b1}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd1, 3'd1}},
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'd2, 1'b1}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd5, 3'd5}},
            // A write to an output that does not exist changes nothing.
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'(NUM_OUT), 1'b1}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd5, 3'd5}},
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'd2, 1'b0}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd1, 3'd1}},
            '{'{mcid_pkg::REQ_ALL_OFF, 8'h00, 32'd0, 2'd0, 1'b0}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 3'd0}},
            // Capture seeds the stable levels from the pins.
            '{'{mcid_pkg::REQ_CAPTURE, 8'hFF, 32'd1000, 2'd0, 1'b0}, 1'b1,
              '{8'hB0, 8'h00, 8'h00, 1'b1, 3'd0, 3'd0}},
            // Every channel flips, then settles at the short and long times.
            '{'{mcid_pkg::REQ_POLL, 8'h00, 32'd1005, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'h00, 32'd1024, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'h00, 32'd1025, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'h00, 32'd1055, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            // Same again across the wrap of the millisecond counter.
            '{'{mcid_pkg::REQ_CAPTURE, 8'h4F, 32'hFFFF_FFF0, 2'd0, 1'b0}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 3'd0}},
            '{'{mcid_pkg::REQ_POLL, 8'hB0, 32'hFFFF_FFF8, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'hB0, 32'h0000_000B, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'hB0, 32'h0000_000C, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'hB0, 32'h0000_002A, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'd1, 1'b1}, 1'b1,
              '{8'hFF, 8'h00, 8'h00, 1'b1, 3'd2, 3'd2}},
            // Inverted outputs, zero short time and the longest long time.
            '{'{mcid_pkg::REQ_CAPTURE, 8'h00, 32'd5, 2'd0, 1'b0}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 3'd7}},
            '{'{mcid_pkg::REQ_POLL, 8'hFF, 32'd5, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'hFF, 32'd5, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_POLL, 8'hFF, 32'd65540, 2'd0, 1'b0}, 1'b0, NO_STATUS},
            '{'{mcid_pkg::REQ_WRITE_OUT, 8'h00, 32'd0, 2'd1, 1'b1}, 1'b1,
              '{8'hFF, 8'h00, 8'h00, 1'b1, 3'd2, 3'd5}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the masks are written wider than the registers.
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (r == RECONFIG_AT) begin
                setup_regs(16'hFFFF, 16'h0000, 16'd0, 16'hFFFF, 16'hFF55);
            end
            send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: setup_regs(16'h0000, 16'hFFFF, 16'd1, 16'd30, 16'h0F0F);
                1: setup_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 16'h00F0);
                default: setup_regs(CFG_W'($urandom), CFG_W'($urandom),
                                    CFG_W'($urandom_range(0, 30)),
                                    CFG_W'($urandom_range(0, 60)), CFG_W'($urandom));
            endcase
            idle_on = (p != 2);
            run_random_phase(PHASE_BEATS);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_status_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, and the field check.
    initial begin : status_sink
        t_status got;
        t_status want;
        int      hold_left;
        bit      hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got = '{res_if.stable_levels, res_if.rose_mask, res_if.fell_mask,
                        res_if.any_active, res_if.out_logic, res_if.out_pins};
                beats_seen++;
                if (pending_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: result beat with nothing pending: %h", $time, got);
                    end
                end else begin
                    want = pending_status_q.pop_front();
                    if (got.stable !== want.stable || got.rose !== want.rose ||
                        got.fell !== want.fell || got.any !== want.any ||
                        got.outs !== want.outs || got.opins !== want.opins) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: beat %0d expected stable %h rose %h fell %h any %b outs %b pins %b",
                                     $time, beats_seen, want.stable, want.rose, want.fell,
                                     want.any, want.outs, want.opins);
                            $display("%0t: beat %0d got      stable %h rose %h fell %h any %b outs %b pins %b",
                                     $time, beats_seen, got.stable, got.rose, got.fell,
                                     got.any, got.outs, got.opins);
                        end
                    end
                end
            end
            // One long hold-off lets the block fill and push back on requests.
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(idle_on && $urandom_range(0, 99) < 6);
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== multi_channel_input_debouncer_unit.f =====
src/mcid_pkg.sv
src/mcid_in_if.sv
src/mcid_out_if.sv
src/mcid_chan.sv
src/multi_channel_input_debouncer_unit.sv
bench/tb_multi_channel_input_debouncer_unit.sv
